// ===== rtl/rdct_pkg.sv =====
// ---------------------------------------------------------------------------
// rdct_pkg
// Shared constants, codes and controller/datapath handshake types for the
// ruler distance conflict table.
// ---------------------------------------------------------------------------
package rdct_pkg;

  localparam int unsigned MaxMarks  = 32;
  localparam int unsigned MarkIdxW  = 5;
  localparam int unsigned MarkCntW  = 6;
  localparam int unsigned PosW      = 10;
  localparam int unsigned HistDepth = 1024;
  localparam int unsigned CntW      = 9;
  localparam int unsigned HitW      = 5;
  localparam int unsigned OpW       = 3;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 10;

  localparam logic [CntW-1:0] CntMax = '1;

  // operation codes
  localparam logic [OpW-1:0] OP_CLEAR = 3'd0;
  localparam logic [OpW-1:0] OP_PLACE = 3'd1;
  localparam logic [OpW-1:0] OP_LIFT  = 3'd2;
  localparam logic [OpW-1:0] OP_PROBE = 3'd3;
  localparam logic [OpW-1:0] OP_QUERY = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MARK_COUNT   = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_RULER_LENGTH = 1'b1;

  // kind of walk over the marks
  typedef enum logic [1:0] {
    PASS_REMOVE,
    PASS_ADD,
    PASS_LOOK,
    PASS_SHARE
  } pass_e;

  typedef struct packed {
    logic  latch;
    logic  sweep_en;
    logic  clear_marks;
    logic  own_read;
    logic  own_capture;
    logic  pass_start;
    pass_e pass_kind;
    logic  set_mark;
    logic  drop_mark;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           mark_ok;
    logic           own_valid;
    logic           pass_idle;
    logic           sweep_last;
  } dp_status_t;

endpackage

// ===== rtl/ruler_distance_conflict_table.sv =====
// ---------------------------------------------------------------------------
// ruler_distance_conflict_table
// Ruler mark store with a pairwise distance histogram and conflict total.
// ---------------------------------------------------------------------------
// a command transfers at a rising edge with start_i high and busy_o low; its
// single result appears for exactly one cycle with done_o high and cannot be
// stalled by the receiver. one command is worked at a time. with n the
// effective mark count (mark_count capped at 32), a place on a valid mark
// walks the n marks twice, removing its old distances and adding new ones;
// a place on a free mark, a lift or query of a valid mark and a probe walk
// them once, lift and query after reading the mark's own position. a lift or
// query of a free mark, an out-of-range index or an unused opcode ends with
// no walk; clear runs the 1024-entry histogram sweep. adding and removing
// walks do one read-modify-write per counted mark through a simple dual-port
// histogram memory. after reset busy_o stays high for a clearing pass over
// the histogram. configuration writes transfer whenever cfg_valid_i is high
// and are meant to be issued while the block is idle
// ---------------------------------------------------------------------------
module ruler_distance_conflict_table import rdct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel
  input  logic                start_i,
  output logic                busy_o,
  input  logic [OpW-1:0]      opcode_i,
  input  logic [MarkIdxW-1:0] mark_index_i,
  input  logic [PosW-1:0]     position_i,
  // result channel
  output logic                done_o,
  output logic [HitW-1:0]     removed_count_o,
  output logic [HitW-1:0]     added_count_o,
  output logic [CntW-1:0]     total_conflicts_o,
  output logic                in_conflict_o,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // registers are plain flops, always ready
  assign cfg_ready_o = 1'b1;

  // sequencer
  rdct_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .cmd_o    (cmd)
  );

  // storage, walk pipeline and counters
  rdct_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .opcode_i          (opcode_i),
    .mark_index_i      (mark_index_i),
    .position_i        (position_i),
    .cfg_write_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .removed_count_o   (removed_count_o),
    .added_count_o     (added_count_o),
    .total_conflicts_o (total_conflicts_o),
    .in_conflict_o     (in_conflict_o)
  );

endmodule

// ===== rtl/rdct_ctrl.sv =====
// ---------------------------------------------------------------------------
// rdct_ctrl
// Operation sequencer: decodes an accepted command and steps the datapath
// through its histogram sweeps and mark walks.
// ---------------------------------------------------------------------------
module rdct_ctrl import rdct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output logic       busy_o,
  output logic       done_o,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [10:0] {
    S_BOOT   = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_DECODE = 11'b000_0000_0100,
    S_CLEAR  = 11'b000_0000_1000,
    S_OWN    = 11'b000_0001_0000,
    S_REMOVE = 11'b000_0010_0000,
    S_ADD    = 11'b000_0100_0000,
    S_LOOK   = 11'b000_1000_0000,
    S_SHARE  = 11'b001_0000_0000,
    S_DONE   = 11'b010_0000_0000,
    S_SPARE  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_BOOT: begin
        cmd_o.sweep_en = 1'b1;
        if (status_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.op == OP_CLEAR) begin
          cmd_o.clear_marks = 1'b1;
          state_d           = S_CLEAR;
        end else if (!status_i.mark_ok) begin
          state_d = S_DONE;
        end else begin
          case (status_i.op)
            OP_PLACE: begin
              if (status_i.own_valid) begin
                cmd_o.own_read = 1'b1;
                state_d        = S_OWN;
              end else begin
                cmd_o.set_mark   = 1'b1;
                cmd_o.pass_start = 1'b1;
                cmd_o.pass_kind  = PASS_ADD;
                state_d          = S_ADD;
              end
            end
            OP_LIFT, OP_QUERY: begin
              if (status_i.own_valid) begin
                cmd_o.own_read = 1'b1;
                state_d        = S_OWN;
              end else begin
                state_d = S_DONE;
              end
            end
            OP_PROBE: begin
              cmd_o.pass_start = 1'b1;
              cmd_o.pass_kind  = PASS_LOOK;
              state_d          = S_LOOK;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.sweep_en = 1'b1;
        if (status_i.sweep_last) state_d = S_DONE;
      end
      S_OWN: begin
        cmd_o.own_capture = 1'b1;
        cmd_o.pass_start  = 1'b1;
        if (status_i.op == OP_QUERY) begin
          cmd_o.pass_kind = PASS_SHARE;
          state_d         = S_SHARE;
        end else begin
          cmd_o.pass_kind = PASS_REMOVE;
          state_d         = S_REMOVE;
        end
      end
      S_REMOVE: begin
        if (status_i.pass_idle) begin
          if (status_i.op == OP_PLACE) begin
            cmd_o.set_mark   = 1'b1;
            cmd_o.pass_start = 1'b1;
            cmd_o.pass_kind  = PASS_ADD;
            state_d          = S_ADD;
          end else begin
            cmd_o.drop_mark = 1'b1;
            state_d         = S_DONE;
          end
        end
      end
      S_ADD, S_LOOK, S_SHARE: begin
        if (status_i.pass_idle) state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not raise busy");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !(cmd_o.pass_start || cmd_o.sweep_en))
    else $error("datapath work started while idle");
`endif

endmodule

// ===== rtl/rdct_datapath.sv =====
// ---------------------------------------------------------------------------
// rdct_datapath
// Mark store, distance histogram memory, three-stage mark walk with
// read-modify-write forwarding, conflict total and configuration registers.
// ---------------------------------------------------------------------------
module rdct_datapath import rdct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  input  logic [OpW-1:0]      opcode_i,
  input  logic [MarkIdxW-1:0] mark_index_i,
  input  logic [PosW-1:0]     position_i,
  input  logic                cfg_write_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic [HitW-1:0]     removed_count_o,
  output logic [HitW-1:0]     added_count_o,
  output logic [CntW-1:0]     total_conflicts_o,
  output logic                in_conflict_o
);

  // configuration
  logic [MarkCntW-1:0] mark_count_q;
  logic [PosW-1:0]     ruler_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_count_q   <= MarkCntW'(2);
      ruler_length_q <= '1;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        REG_MARK_COUNT:   mark_count_q   <= cfg_data_i[MarkCntW-1:0];
        REG_RULER_LENGTH: ruler_length_q <= cfg_data_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  // latched command
  logic [OpW-1:0]      op_q;
  logic [MarkIdxW-1:0] idx_q;
  logic [PosW-1:0]     pos_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= opcode_i;
      idx_q <= mark_index_i;
      pos_q <= position_i;
    end
  end

  logic [MarkCntW-1:0] n_eff;
  assign n_eff = (mark_count_q > MarkCntW'(MaxMarks)) ? MarkCntW'(MaxMarks) : mark_count_q;

  // mark valid bits
  logic [MaxMarks-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clear_marks) begin
      valid_q <= '0;
    end else if (cmd_i.set_mark) begin
      valid_q[idx_q] <= 1'b1;
    end else if (cmd_i.drop_mark) begin
      valid_q[idx_q] <= 1'b0;
    end
  end

  // walk control
  logic                active_q, active_d;
  logic [MarkIdxW-1:0] j_q, j_d;
  pass_e               kind_q, kind_d;
  logic                j_last;

  assign j_last = ({1'b0, j_q} == (n_eff - MarkCntW'(1)));

  always_comb begin
    active_d = active_q;
    j_d      = j_q;
    kind_d   = kind_q;
    if (cmd_i.pass_start) begin
      active_d = 1'b1;
      j_d      = '0;
      kind_d   = cmd_i.pass_kind;
    end else if (active_q) begin
      if (j_last) begin
        active_d = 1'b0;
      end else begin
        j_d = j_q + MarkIdxW'(1);
      end
    end
  end

  // position memory
  logic [PosW-1:0]     pos_mem [MaxMarks];
  logic [PosW-1:0]     pos_rdata_q;
  logic [PosW-1:0]     own_pos_q;
  logic [MarkIdxW-1:0] pos_raddr;

  assign pos_raddr = cmd_i.own_read ? idx_q : j_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_mark) pos_mem[idx_q] <= pos_q;
    pos_rdata_q <= pos_mem[pos_raddr];
    if (cmd_i.own_capture) own_pos_q <= pos_rdata_q;
  end

  // stage 1: distance and histogram read
  logic            s1_v_q, s2_v_q;
  logic [PosW-1:0] s2_d_q;
  logic [PosW-1:0] ref_pos;
  logic [PosW-1:0] pair_gap;
  logic            in_range;

  assign ref_pos  = (kind_q == PASS_ADD || kind_q == PASS_LOOK) ? pos_q : own_pos_q;
  assign pair_gap = (ref_pos >= pos_rdata_q) ? (ref_pos - pos_rdata_q)
                                             : (pos_rdata_q - ref_pos);
  assign in_range = (pair_gap <= ruler_length_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      j_q      <= '0;
      kind_q   <= PASS_REMOVE;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      j_q      <= j_d;
      kind_q   <= kind_d;
      s1_v_q   <= active_q && (j_q != idx_q) && valid_q[j_q];
      s2_v_q   <= s1_v_q && in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_d_q <= pair_gap;
  end

  // histogram memory
  logic [CntW-1:0] hist_mem [HistDepth];
  logic [CntW-1:0] hist_rdata_q;
  logic            hist_we;
  logic [PosW-1:0] hist_wa;
  logic [CntW-1:0] hist_wd;
  logic            wr_v_q;
  logic [PosW-1:0] wr_a_q;
  logic [CntW-1:0] wr_data_q;
  logic [PosW-1:0] sweep_a_q;

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    hist_rdata_q <= hist_mem[pair_gap];
    wr_a_q       <= hist_wa;
    wr_data_q    <= hist_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_v_q    <= 1'b0;
      sweep_a_q <= '0;
    end else begin
      wr_v_q <= hist_we;
      if (cmd_i.sweep_en) sweep_a_q <= sweep_a_q + PosW'(1);
    end
  end

  // stage 2: read-modify-write and counting
  logic [HitW-1:0] removed_q, removed_d;
  logic [HitW-1:0] added_q, added_d;
  logic            flag_q, flag_d;
  logic [CntW-1:0] total_q, total_d;
  logic [CntW-1:0] cur_cnt;

  // a write from the previous cycle is not yet in the registered read
  assign cur_cnt = (wr_v_q && (wr_a_q == s2_d_q)) ? wr_data_q : hist_rdata_q;

  always_comb begin
    hist_we   = 1'b0;
    hist_wa   = s2_d_q;
    hist_wd   = cur_cnt;
    removed_d = removed_q;
    added_d   = added_q;
    flag_d    = flag_q;
    total_d   = total_q;
    if (cmd_i.sweep_en) begin
      hist_we = 1'b1;
      hist_wa = sweep_a_q;
      hist_wd = '0;
    end else if (s2_v_q) begin
      case (kind_q)
        PASS_REMOVE: begin
          if (cur_cnt > CntW'(1)) begin
            removed_d = removed_q + HitW'(1);
            if (total_q != '0) total_d = total_q - CntW'(1);
          end
          if (cur_cnt != '0) begin
            hist_we = 1'b1;
            hist_wd = cur_cnt - CntW'(1);
          end
        end
        PASS_ADD: begin
          if (cur_cnt != '0) begin
            added_d = added_q + HitW'(1);
            if (total_q != CntMax) total_d = total_q + CntW'(1);
          end
          if (cur_cnt != CntMax) begin
            hist_we = 1'b1;
            hist_wd = cur_cnt + CntW'(1);
          end
        end
        PASS_LOOK: begin
          if (cur_cnt != '0) added_d = added_q + HitW'(1);
        end
        PASS_SHARE: begin
          if (cur_cnt > CntW'(1)) flag_d = 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd_i.latch) begin
      removed_d = '0;
      added_d   = '0;
      flag_d    = 1'b0;
    end
    if (cmd_i.clear_marks) total_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      removed_q <= '0;
      added_q   <= '0;
      flag_q    <= 1'b0;
      total_q   <= '0;
    end else begin
      removed_q <= removed_d;
      added_q   <= added_d;
      flag_q    <= flag_d;
      total_q   <= total_d;
    end
  end

  // status
  assign status_o.op         = op_q;
  assign status_o.mark_ok    = ({1'b0, idx_q} < n_eff) && (op_q <= OP_QUERY);
  assign status_o.own_valid  = valid_q[idx_q];
  assign status_o.pass_idle  = !active_q && !s1_v_q && !s2_v_q;
  assign status_o.sweep_last = (sweep_a_q == '1);

  assign removed_count_o   = removed_q;
  assign added_count_o     = added_q;
  assign total_conflicts_o = total_q;
  assign in_conflict_o     = flag_q;

`ifndef SYNTHESIS
  a_sweep_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.sweep_en && (active_q || s1_v_q || s2_v_q)))
    else $error("histogram sweep overlaps a mark walk");

  a_pass_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pass_start |-> !active_q)
    else $error("mark walk restarted while running");

  a_latch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.latch |=> (removed_q == '0 && added_q == '0 && !flag_q))
    else $error("result counts not cleared on a new command");
`endif

endmodule
